/* sv/rpsc_pkg.sv */
`default_nettype none
package rpsc_pkg;

    localparam int MAX_STAGES = 24;
    localparam int RANGE_W    = 48;
    localparam int CW         = 34;   // CORDIC datapath width, Q2.30 plus headroom
    localparam int MAG_W      = 33;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] QUARTER     = 34'sd1073741824;
    localparam logic signed [CW-1:0] HALF        = 34'sd2147483648;

    localparam logic [31:0] ATAN_TURNS [MAX_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [3:0] {
        REG_RANGE_STEP = 4'd0,
        REG_AZ_START   = 4'd1,
        REG_AZ_STEP    = 4'd2,
        REG_EL_START   = 4'd3,
        REG_EL_STEP    = 4'd4,
        REG_MAX_RANGE  = 4'd5,
        REG_HORIZ_SCALE = 4'd6,
        REG_VERT_SCALE = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } ang_t;

    typedef struct packed {
        logic [RANGE_W-1:0] r;
        logic               in_range;
        logic [31:0]        ox;
        logic [31:0]        oy;
        logic [31:0]        oz;
        logic [15:0]        amp;
        logic               last;
    } side_t;

    typedef struct packed {
        ang_t  az;
        ang_t  el;
        side_t side;
    } cell_t;

    // fold a 16-bit angle into -90..+90 degrees, start vector at CORDIC gain
    function automatic ang_t fold(input logic [15:0] a);
        ang_t                 res;
        logic signed [CW-1:0] z;
        z = {{2{a[15]}}, a, 16'h0000};
        res.x    = CORDIC_GAIN;
        res.y    = '0;
        res.flip = 1'b0;
        if (z > QUARTER)
        begin
            z        = z - HALF;
            res.flip = 1'b1;
        end
        else if (z < -QUARTER)
        begin
            z        = z + HALF;
            res.flip = 1'b1;
        end
        res.z = z;
        return res;
    endfunction

    function automatic ang_t rotate(input ang_t a, input int idx);
        ang_t                 res;
        logic signed [CW-1:0] xv;
        logic signed [CW-1:0] yv;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] at;
        xv = a.x;
        yv = a.y;
        dx = yv >>> idx;
        dy = xv >>> idx;
        at = {2'b00, ATAN_TURNS[idx]};
        res.flip = a.flip;
        if (!a.z[CW-1])
        begin
            res.x = xv - dx;
            res.y = yv + dy;
            res.z = a.z - at;
        end
        else
        begin
            res.x = xv + dx;
            res.y = yv - dy;
            res.z = a.z + at;
        end
        return res;
    endfunction

    function automatic logic [MAG_W-1:0] mag(input logic signed [CW-1:0] v);
        logic [CW-1:0] u;
        u = v[CW-1] ? (~v + 1'b1) : v;
        return u[MAG_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* sv/rpsc_front.sv */
`default_nettype none
module rpsc_front
    import rpsc_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] range_bin,
    input  wire logic [15:0] azimuth_bin,
    input  wire logic [15:0] elevation_bin,
    input  wire logic [15:0] amplitude,
    input  wire logic [31:0] origin_x,
    input  wire logic [31:0] origin_y,
    input  wire logic [31:0] origin_z,
    input  wire logic        last_point,
    input  wire logic [31:0] range_step,
    input  wire logic [15:0] azimuth_start,
    input  wire logic [15:0] azimuth_step,
    input  wire logic [15:0] elevation_start,
    input  wire logic [15:0] elevation_step,
    input  wire logic [RANGE_W-1:0] max_range,
    output logic             out_valid,
    input  wire logic        out_ready,
    output cell_t            out_item
);

    localparam int KEEP = (ANGLE_BITS < 1) ? 1 : ((ANGLE_BITS < 16) ? ANGLE_BITS : 16);
    localparam logic [15:0] ANG_MASK = 16'hFFFF << (16 - KEEP);

    logic        v0_reg, v1_reg;
    logic        adv0, adv1;
    side_t       side0_reg, side0_next;
    logic [15:0] az0_reg, az0_next, el0_reg, el0_next;
    cell_t       item1_reg, item1_next;
    logic [31:0] az_prod, el_prod;

    assign adv1     = !v1_reg || out_ready;
    assign adv0     = !v0_reg || adv1;
    assign in_ready = adv0;
    assign out_valid = v1_reg;
    assign out_item  = item1_reg;

    always_comb
    begin
        az_prod = azimuth_bin * azimuth_step;
        el_prod = elevation_bin * elevation_step;
        az0_next = (azimuth_start + az_prod[15:0]) & ANG_MASK;
        el0_next = (elevation_start + el_prod[15:0]) & ANG_MASK;
        side0_next.r        = range_bin * range_step;
        side0_next.in_range = 1'b0;
        side0_next.ox       = origin_x;
        side0_next.oy       = origin_y;
        side0_next.oz       = origin_z;
        side0_next.amp      = amplitude;
        side0_next.last     = last_point;

        item1_next                = '0;
        item1_next.az             = fold(az0_reg);
        item1_next.el             = fold(el0_reg);
        item1_next.side           = side0_reg;
        item1_next.side.in_range  = (side0_reg.r <= max_range);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
            begin
                v0_reg <= in_valid;
            end
            if (adv1)
            begin
                v1_reg <= v0_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv0 && in_valid)
        begin
            side0_reg <= side0_next;
            az0_reg   <= az0_next;
            el0_reg   <= el0_next;
        end
        if (adv1 && v0_reg)
        begin
            item1_reg <= item1_next;
        end
    end

endmodule
`default_nettype wire

/* sv/rpsc_cordic_cell.sv */
`default_nettype none
module rpsc_cordic_cell
    import rpsc_pkg::*;
#(
    parameter int STAGE_IDX = 0
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cell_t in_item,
    output logic      out_valid,
    input  wire logic out_ready,
    output cell_t     out_item
);

    logic  v_reg;
    cell_t item_reg, item_next;
    logic  adv;

    assign adv       = !v_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg;
    assign out_item  = item_reg;

    // one micro-rotation on both angles
    always_comb
    begin
        item_next      = in_item;
        item_next.az   = rotate(in_item.az, STAGE_IDX);
        item_next.el   = rotate(in_item.el, STAGE_IDX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

/* sv/rpsc_place.sv */
`default_nettype none
module rpsc_place
    import rpsc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire cell_t       in_item,
    input  wire logic [31:0] horiz_scale,
    input  wire logic [31:0] vert_scale,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             in_range,
    output logic [31:0]      scene_x,
    output logic [31:0]      scene_y,
    output logic [31:0]      scene_z,
    output logic [15:0]      amplitude_out,
    output logic             last_out
);

    localparam int NPS = 5;
    localparam int PW  = 51;   // r * f >> 30
    localparam int QW  = 67;   // p * scale >> 16

    logic [NPS-1:0] v_reg;
    logic [NPS-1:0] adv;

    side_t side_reg [NPS-1];
    logic [2:0] neg_reg [NPS-1];

    logic [MAG_W-1:0] f_reg  [3];
    logic [MAG_W-1:0] f_next [3];
    logic [64:0]      pplo_reg [3];
    logic [48:0]      pphi_reg [3];
    logic [PW-1:0]    p_reg  [3];
    logic [PW-1:0]    p_next [3];
    logic [63:0]      qa_reg [3];
    logic [50:0]      qb_reg [3];
    logic [31:0]      sc_next [3];
    logic [31:0]      sc_reg  [3];
    logic [2:0]       neg_next;
    logic [31:0]      scale [3];
    logic [31:0]      orig  [3];
    logic             ir_reg, last_reg;
    logic [15:0]      amp_reg;

    logic [MAG_W-1:0] ma_s, ma_c, me_s, me_c;
    logic             sa_neg, ca_neg, se_neg, ce_neg;
    logic [65:0]      sace_full, cace_full;
    logic [80:0]      pfull;
    logic [82:0]      qfull;
    logic [QW-1:0]    q;
    logic [33:0]      qc;
    logic signed [34:0] sum;

    always_comb
    begin
        adv[NPS-1] = !v_reg[NPS-1] || out_ready;
        for (int k = NPS - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign in_ready      = adv[0];
    assign out_valid     = v_reg[NPS-1];
    assign in_range      = ir_reg;
    assign scene_x       = sc_reg[0];
    assign scene_y       = sc_reg[1];
    assign scene_z       = sc_reg[2];
    assign amplitude_out = amp_reg;
    assign last_out      = last_reg;

    assign scale[0] = horiz_scale;
    assign scale[1] = vert_scale;
    assign scale[2] = horiz_scale;
    assign orig[0]  = side_reg[3].ox;
    assign orig[1]  = side_reg[3].oy;
    assign orig[2]  = side_reg[3].oz;

    // magnitudes and signs after the half-turn flip
    always_comb
    begin
        ma_s   = mag(in_item.az.y);
        ma_c   = mag(in_item.az.x);
        me_s   = mag(in_item.el.y);
        me_c   = mag(in_item.el.x);
        sa_neg = in_item.az.flip ? (in_item.az.y > 0) : in_item.az.y[CW-1];
        ca_neg = in_item.az.flip ? (in_item.az.x > 0) : in_item.az.x[CW-1];
        se_neg = in_item.el.flip ? (in_item.el.y > 0) : in_item.el.y[CW-1];
        ce_neg = in_item.el.flip ? (in_item.el.x > 0) : in_item.el.x[CW-1];
        sace_full = ma_s * me_c;
        cace_full = ma_c * me_c;
        f_next[0] = sace_full[62:30];
        f_next[1] = me_s;
        f_next[2] = cace_full[62:30];
        neg_next[0] = !(sa_neg != ce_neg);
        neg_next[1] = se_neg;
        neg_next[2] = ca_neg != ce_neg;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pfull     = {pphi_reg[i], 32'h0} + {16'h0, pplo_reg[i]};
            p_next[i] = pfull[80:30];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qfull = {qb_reg[i], 32'h0} + {19'h0, qa_reg[i]};
            q     = qfull[82:16];
            // anything at or above 2^33 saturates whatever the origin
            qc    = (|q[QW-1:33]) ? {1'b1, 33'h0} : q[33:0];
            if (neg_reg[3][i])
            begin
                sum = {{3{orig[i][31]}}, orig[i]} - $signed({1'b0, qc});
            end
            else
            begin
                sum = {{3{orig[i][31]}}, orig[i]} + $signed({1'b0, qc});
            end
            if (!side_reg[3].in_range)
            begin
                sc_next[i] = '0;
            end
            else if (sum > 35'sd2147483647)
            begin
                sc_next[i] = 32'h7FFFFFFF;
            end
            else if (sum < -35'sd2147483648)
            begin
                sc_next[i] = 32'h80000000;
            end
            else
            begin
                sc_next[i] = sum[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NPS; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
        begin
            side_reg[0] <= in_item.side;
            neg_reg[0]  <= neg_next;
            f_reg       <= f_next;
        end
        if (adv[1] && v_reg[0])
        begin
            side_reg[1] <= side_reg[0];
            neg_reg[1]  <= neg_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                pplo_reg[i] <= side_reg[0].r[31:0] * f_reg[i];
                pphi_reg[i] <= side_reg[0].r[47:32] * f_reg[i];
            end
        end
        if (adv[2] && v_reg[1])
        begin
            side_reg[2] <= side_reg[1];
            neg_reg[2]  <= neg_reg[1];
            p_reg       <= p_next;
        end
        if (adv[3] && v_reg[2])
        begin
            side_reg[3] <= side_reg[2];
            neg_reg[3]  <= neg_reg[2];
            for (int i = 0; i < 3; i++)
            begin
                qa_reg[i] <= p_reg[i][31:0] * scale[i];
                qb_reg[i] <= p_reg[i][PW-1:32] * scale[i];
            end
        end
        if (adv[4] && v_reg[3])
        begin
            sc_reg   <= sc_next;
            ir_reg   <= side_reg[3].in_range;
            amp_reg  <= side_reg[3].amp;
            last_reg <= side_reg[3].last;
        end
    end

endmodule
`default_nettype wire

/* sv/radar_point_to_scene_coords.sv */
// Radar return to scene coordinate converter.
// Input channel: in_valid / in_stall with one radar return per item (bin
// indices, amplitude, sector origin, last flag). Output channel: out_valid /
// out_stall with one result per item (in_range, scene_x/y/z, amplitude_out,
// last_out). Configuration: cfg_valid / cfg_ready write port, cfg_index picks
// the register, cfg_data carries the value; cfg_ready is always high and
// unknown indexes are dropped. Write registers only while the pipe is empty.
// Throughput is one item per cycle while out_stall is low. The pipe has
// two front stages (bin products, range check and angle fold), one CORDIC
// cell per micro-rotation, five stages of magnitude products, range and
// scale multiplies split into partial products, and the saturating add.
// Each stage holds its item while the stage after it is full and stalled, so
// bubbles close up; in_stall rises once every stage holds an item and
// out_stall is high. Reset empties the pipe and loads the register defaults.
`default_nettype none
module radar_point_to_scene_coords
    import rpsc_pkg::*;
#(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] range_bin,
    input  wire logic [15:0] azimuth_bin,
    input  wire logic [15:0] elevation_bin,
    input  wire logic [15:0] amplitude,
    input  wire logic [31:0] origin_x,
    input  wire logic [31:0] origin_y,
    input  wire logic [31:0] origin_z,
    input  wire logic        last_point,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             in_range,
    output logic [31:0]      scene_x,
    output logic [31:0]      scene_y,
    output logic [31:0]      scene_z,
    output logic [15:0]      amplitude_out,
    output logic             last_out,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    localparam int NST = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;

    logic [31:0]        range_step_reg;
    logic [15:0]        az_start_reg, az_step_reg, el_start_reg, el_step_reg;
    logic [RANGE_W-1:0] max_range_reg;
    logic [31:0]        horiz_scale_reg, vert_scale_reg;

    logic  chain_valid [NST+1];
    logic  chain_ready [NST+1];
    cell_t chain_item  [NST+1];
    logic  front_ready;

    assign cfg_ready = 1'b1;
    assign in_stall  = !front_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_step_reg  <= 32'd65536;
            az_start_reg    <= 16'd0;
            az_step_reg     <= 16'd1;
            el_start_reg    <= 16'd0;
            el_step_reg     <= 16'd1;
            max_range_reg   <= {RANGE_W{1'b1}};
            horiz_scale_reg <= 32'd65536;
            vert_scale_reg  <= 32'd65536;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RANGE_STEP:  range_step_reg  <= cfg_data[31:0];
                REG_AZ_START:    az_start_reg    <= cfg_data[15:0];
                REG_AZ_STEP:     az_step_reg     <= cfg_data[15:0];
                REG_EL_START:    el_start_reg    <= cfg_data[15:0];
                REG_EL_STEP:     el_step_reg     <= cfg_data[15:0];
                REG_MAX_RANGE:   max_range_reg   <= cfg_data[RANGE_W-1:0];
                REG_HORIZ_SCALE: horiz_scale_reg <= cfg_data[31:0];
                REG_VERT_SCALE:  vert_scale_reg  <= cfg_data[31:0];
                default:         ;
            endcase
        end
    end

    rpsc_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (front_ready),
        .range_bin       (range_bin),
        .azimuth_bin     (azimuth_bin),
        .elevation_bin   (elevation_bin),
        .amplitude       (amplitude),
        .origin_x        (origin_x),
        .origin_y        (origin_y),
        .origin_z        (origin_z),
        .last_point      (last_point),
        .range_step      (range_step_reg),
        .azimuth_start   (az_start_reg),
        .azimuth_step    (az_step_reg),
        .elevation_start (el_start_reg),
        .elevation_step  (el_step_reg),
        .max_range       (max_range_reg),
        .out_valid       (chain_valid[0]),
        .out_ready       (chain_ready[0]),
        .out_item        (chain_item[0])
    );

    for (genvar g = 0; g < NST; g++)
    begin : g_cell
        rpsc_cordic_cell #(
            .STAGE_IDX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_item   (chain_item[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_item  (chain_item[g+1])
        );
    end

    rpsc_place u_place (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (chain_valid[NST]),
        .in_ready      (chain_ready[NST]),
        .in_item       (chain_item[NST]),
        .horiz_scale   (horiz_scale_reg),
        .vert_scale    (vert_scale_reg),
        .out_valid     (out_valid),
        .out_ready     (!out_stall),
        .in_range      (in_range),
        .scene_x       (scene_x),
        .scene_y       (scene_y),
        .scene_z       (scene_z),
        .amplitude_out (amplitude_out),
        .last_out      (last_out)
    );

endmodule
`default_nettype wire

/* dv/tb_radar_point_to_scene_coords.sv */
`timescale 1ns / 100ps
module tb_radar_point_to_scene_coords;
    import rpsc_pkg::*;

    localparam int          STAGES   = 16;
    localparam int          SETTLE   = 60;    // extra wait once every expected item has come out
    localparam int          N_DEF    = 13;    // rows run with the reset settings
    localparam int          N_ROWS   = 16;
    localparam int          N_PHASES = 8;
    localparam int          PHASE_N  = 240;
    localparam logic [63:0] MAG_CAP  = 64'h4000_0000_0000_0000;

    typedef struct {
        logic [15:0] rb;
        logic [15:0] ab;
        logic [15:0] eb;
        logic [15:0] amp;
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] oz;
        logic        last;
    } point_t;

    typedef struct {
        logic        inr;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] amp;
        logic        last;
    } coord_t;

    typedef struct {
        point_t      p;
        bit          typed;
        logic        inr;
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] ez;
    } row_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [15:0] range_bin     = '0;
    logic [15:0] azimuth_bin   = '0;
    logic [15:0] elevation_bin = '0;
    logic [15:0] amplitude     = '0;
    logic [31:0] origin_x      = '0;
    logic [31:0] origin_y      = '0;
    logic [31:0] origin_z      = '0;
    logic        last_point    = 1'b0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic        in_range;
    logic [31:0] scene_x;
    logic [31:0] scene_y;
    logic [31:0] scene_z;
    logic [15:0] amplitude_out;
    logic        last_out;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index     = '0;
    logic [47:0] cfg_data      = '0;

    // register shadow
    logic [31:0] cfg_range_step = 32'd65536;
    logic [15:0] cfg_az_start   = 16'd0;
    logic [15:0] cfg_az_step    = 16'd1;
    logic [15:0] cfg_el_start   = 16'd0;
    logic [15:0] cfg_el_step    = 16'd1;
    logic [47:0] cfg_max_range  = 48'hFFFF_FFFF_FFFF;
    logic [31:0] cfg_hscale     = 32'd65536;
    logic [31:0] cfg_vscale     = 32'd65536;

    coord_t pending_q[$];
    int     errors     = 0;
    int     burst_left = 0;
    bit     hold_go    = 1'b0;
    bit     hold_on    = 1'b0;
    int     stall_cnt  = 0;
    int     stall_mode = 0;

    radar_point_to_scene_coords dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("tb_radar_point_to_scene_coords: FAIL");
        $finish;
    end

    function automatic logic [63:0] mul_cap(input logic [63:0] a, input logic [63:0] b,
                                            input int s);
        logic [127:0] pr;
        pr = ({64'd0, a} * {64'd0, b}) >> s;
        if (pr > {64'd0, MAG_CAP})
            return MAG_CAP;
        return pr[63:0];
    endfunction

    function automatic void sincos(input logic [15:0] a16, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z    = longint'($signed({a16, 16'h0000}));
        x    = 652032874;
        y    = 0;
        flip = 1'b0;
        if (z > 64'sd1073741824)
        begin
            z    = z - 64'sd2147483648;
            flip = 1'b1;
        end
        else if (z < -64'sd1073741824)
        begin
            z    = z + 64'sd2147483648;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TURNS[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TURNS[i]);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic logic [63:0] absval(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [31:0] place(input logic [31:0] origin, input bit neg,
                                          input logic [63:0] r, input logic [63:0] f,
                                          input logic [63:0] scale);
        logic [63:0] q;
        longint      v;
        q = mul_cap(mul_cap(r, f, 30), scale, 16);
        v = longint'($signed(origin)) + (neg ? -longint'(q) : longint'(q));
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic coord_t scene_of(input point_t p);
        coord_t      res;
        logic [63:0] r;
        logic [15:0] az;
        logic [15:0] el;
        longint      ca;
        longint      sa;
        longint      ce;
        longint      se;
        logic [63:0] sace;
        logic [63:0] cace;
        r        = 64'(p.rb) * 64'(cfg_range_step);
        res.inr  = 1'b0;
        res.x    = '0;
        res.y    = '0;
        res.z    = '0;
        res.amp  = p.amp;
        res.last = p.last;
        if (r <= 64'(cfg_max_range))
        begin
            az = cfg_az_start + p.ab * cfg_az_step;
            el = cfg_el_start + p.eb * cfg_el_step;
            sincos(az, ca, sa);
            sincos(el, ce, se);
            sace    = (absval(sa) * absval(ce)) >> 30;
            cace    = (absval(ca) * absval(ce)) >> 30;
            res.inr = 1'b1;
            res.x   = place(p.ox, !((sa < 0) != (ce < 0)), r, sace, 64'(cfg_hscale));
            res.y   = place(p.oy, se < 0, r, absval(se), 64'(cfg_vscale));
            res.z   = place(p.oz, (ca < 0) != (ce < 0), r, cace, 64'(cfg_hscale));
        end
        return res;
    endfunction

    task automatic send_point(input point_t p, input bit typed, input coord_t want);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        range_bin     <= p.rb;
        azimuth_bin   <= p.ab;
        elevation_bin <= p.eb;
        amplitude     <= p.amp;
        origin_x      <= p.ox;
        origin_y      <= p.oy;
        origin_z      <= p.oz;
        last_point    <= p.last;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_q.push_back(typed ? want : scene_of(p));
        burst_left--;
    endtask

    // stop offering and let the pipe run dry
    task automatic drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [47:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RANGE_STEP:  cfg_range_step = data[31:0];
            REG_AZ_START:    cfg_az_start   = data[15:0];
            REG_AZ_STEP:     cfg_az_step    = data[15:0];
            REG_EL_START:    cfg_el_start   = data[15:0];
            REG_EL_STEP:     cfg_el_step    = data[15:0];
            REG_MAX_RANGE:   cfg_max_range  = data;
            REG_HORIZ_SCALE: cfg_hscale     = data[31:0];
            REG_VERT_SCALE:  cfg_vscale     = data[31:0];
            default: ;
        endcase
    endtask

    // sel 0: top, 1: zero, 2: nominal, 3: random
    function automatic logic [47:0] pick(input int sel, input int width,
                                         input logic [47:0] nominal);
        logic [47:0] top;
        top = (48'd1 << width) - 48'd1;
        case (sel)
            0: return top;
            1: return '0;
            2: return nominal;
            default: return 48'({$urandom, $urandom}) & top;
        endcase
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        coord_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
                report("unexpected item", 64'(scene_x), 64'(0));
            else
            begin
                want = pending_q.pop_front();
                if (in_range !== want.inr)
                    report("in_range", 64'(in_range), 64'(want.inr));
                if (scene_x !== want.x)
                    report("scene_x", 64'(scene_x), 64'(want.x));
                if (scene_y !== want.y)
                    report("scene_y", 64'(scene_y), 64'(want.y));
                if (scene_z !== want.z)
                    report("scene_z", 64'(scene_z), 64'(want.z));
                if (amplitude_out !== want.amp)
                    report("amplitude_out", 64'(amplitude_out), 64'(want.amp));
                if (last_out !== want.last)
                    report("last_out", 64'(last_out), 64'(want.last));
            end
        end
    end

    // receiver back-pressure from one of four patterns, re-picked at random by stall_cnt
    always @(posedge clk)
    begin
        stall_cnt++;
        if (stall_cnt % 97 == 0)
            stall_mode = $urandom_range(0, 3);
        if (hold_on)
            out_stall <= 1'b1;
        else
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= (stall_cnt % 5 < 2);
            endcase
    end

    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_on = 1'b1;
        repeat (400) @(posedge clk);
        hold_on = 1'b0;
    end

    initial
    begin
        row_t   rows [N_ROWS];
        coord_t want;
        point_t p;
        int     sel;
        rows = '{
            '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 1'b0},
              1'b1, 1'b1, 32'h0, 32'h0, 32'h0},
            '{'{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7FFFFFFF, 32'h80000000,
                32'h7FFFFFFF, 1'b1},
              1'b1, 1'b1, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF},
            '{'{16'h0000, 16'h8000, 16'h4000, 16'h1234, 32'h80000000, 32'h7FFFFFFF,
                32'h80000000, 1'b0},
              1'b1, 1'b1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000},
            '{'{16'h0001, 16'h0000, 16'h0000, 16'h0100, 32'h0, 32'h0, 32'h0, 1'b0},
              1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
            '{'{16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 32'h0, 32'h0, 32'h7FFFFFFF, 1'b0},
              1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
            '{'{16'hFFFF, 16'h4000, 16'h0000, 16'h0002, 32'h0, 32'h0, 32'h0, 1'b0},
              1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
            '{'{16'hFFFF, 16'h8000, 16'h0000, 16'h0004, 32'h0, 32'h0, 32'h0, 1'b1},
              1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
            '{'{16'hFFFF, 16'hC000, 16'h0000, 16'h0008, 32'h0, 32'h0, 32'h80000000, 1'b0},
              1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
            '{'{16'h0100, 16'h0000, 16'h4000, 16'h0010, 32'h0, 32'h0, 32'h0, 1'b0},
              1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
            '{'{16'h0100, 16'h0000, 16'hC000, 16'h0020, 32'h0, 32'h80000000, 32'h0, 1'b0},
              1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
            '{'{16'h0100, 16'h2000, 16'h2000, 16'h0040, 32'h00010000, 32'hFFFF0000,
                32'h00020000, 1'b0},
              1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
            '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h7FFFFFFF, 1'b1},
              1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
            '{'{16'h8000, 16'h5555, 16'hAAAA, 16'h5A5A, 32'h12345678, 32'hEDCBA987,
                32'h0F0F0F0F, 1'b1},
              1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
            // max_range at zero from here on: anything but range zero is rejected
            '{'{16'h0001, 16'h0000, 16'h0000, 16'hABCD, 32'h11111111, 32'h22222222,
                32'h33333333, 1'b1},
              1'b1, 1'b0, 32'h0, 32'h0, 32'h0},
            '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h80000000, 32'h7FFFFFFF,
                32'hFFFFFFFF, 1'b0},
              1'b1, 1'b0, 32'h0, 32'h0, 32'h0},
            '{'{16'h0000, 16'h1234, 16'h4321, 16'h00FF, 32'h11111111, 32'h22222222,
                32'h33333333, 1'b1},
              1'b1, 1'b1, 32'h11111111, 32'h22222222, 32'h33333333}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
        begin
            if (i == N_DEF)
            begin
                drain();
                write_reg(REG_MAX_RANGE, 48'h0);
            end
            want.inr  = rows[i].inr;
            want.x    = rows[i].ex;
            want.y    = rows[i].ey;
            want.z    = rows[i].ez;
            want.amp  = rows[i].p.amp;
            want.last = rows[i].p.last;
            send_point(rows[i].p, rows[i].typed, want);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain();
            write_reg(REG_RANGE_STEP, pick((ph + 2) % 4, 32, 48'd65536));
            write_reg(REG_AZ_START, pick((ph + 3) % 4, 16, 48'd0));
            sel = ph % 4;
            write_reg(REG_AZ_STEP, sel == 0 ? 48'h7FFF : sel == 1 ? 48'h8000 :
                      sel == 2 ? 48'(16'($urandom_range(0, 64) - 32)) : 48'($urandom));
            write_reg(REG_EL_START, pick((ph + 1) % 4, 16, 48'd0));
            sel = (ph + 1) % 4;
            write_reg(REG_EL_STEP, sel == 0 ? 48'h7FFF : sel == 1 ? 48'h8000 :
                      sel == 2 ? 48'(16'($urandom_range(0, 64) - 32)) : 48'($urandom));
            sel = (ph + 2) % 4;
            write_reg(REG_MAX_RANGE, sel == 0 ? 48'hFFFF_FFFF_FFFF : sel == 1 ? 48'h0 :
                      48'($urandom));
            write_reg(REG_HORIZ_SCALE, pick(ph % 4, 32, 48'd65536));
            write_reg(REG_VERT_SCALE, pick((ph + 3) % 4, 32, 48'd65536));
            if (ph == 2)
                write_reg(4'($urandom_range(8, 15)), 48'({$urandom, $urandom}));
            if (ph == 1)
                hold_go = 1'b1;
            for (int n = 0; n < PHASE_N; n++)
            begin
                p.rb   = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 255)) :
                         16'($urandom);
                p.ab   = 16'($urandom);
                p.eb   = 16'($urandom);
                p.amp  = 16'($urandom);
                p.last = ($urandom_range(0, 15) == 0);
                if ($urandom_range(0, 3) == 0)
                begin
                    p.ox = $urandom;
                    p.oy = $urandom;
                    p.oz = $urandom;
                end
                else
                begin
                    p.ox = 32'($signed(21'($urandom)));
                    p.oy = 32'($signed(21'($urandom)));
                    p.oz = 32'($signed(21'($urandom)));
                end
                send_point(p, 1'b0, want);
            end
        end

        drain();
        if (errors == 0 && pending_q.size() == 0)
            $display("tb_radar_point_to_scene_coords: PASS");
        else
            $display("tb_radar_point_to_scene_coords: FAIL");
        $finish;
    end

endmodule

/* sim.f */
sv/rpsc_pkg.sv
sv/rpsc_front.sv
sv/rpsc_cordic_cell.sv
sv/rpsc_place.sv
sv/radar_point_to_scene_coords.sv
dv/tb_radar_point_to_scene_coords.sv
